/* design/lmsn_pkg.sv */
`timescale 1ns / 1ps
// lmsn_pkg: shared types, codes and helpers for the LMS neuron trainer.
// No dependencies; imported by the interface users, cells, head and top.
package lmsn_pkg;

  localparam int unsigned FEAT_W   = 48;
  localparam int unsigned TGT_W    = 4;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned LR_W     = 16;
  localparam int unsigned THR_W    = 31;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 31;

  localparam int unsigned RATE_FRAC = 16;
  localparam int unsigned ERR_W     = WEIGHT_W + 2;
  localparam int unsigned PROD_W    = LR_W + 1 + WEIGHT_W;
  localparam int unsigned DELTA_W   = PROD_W + 1 - RATE_FRAC;
  localparam int unsigned UPD_W     = DELTA_W + 1;

  localparam logic [LR_W-1:0] LR_RESET = LR_W'(655);

  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = CFG_IDX_W'(1);

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [MODE_W-1:0] {
    MODE_TRAIN = 2'd0,
    MODE_EVAL  = 2'd1,
    MODE_CLASS = 2'd2
  } mode_e;

  typedef struct packed {
    logic [FEAT_W-1:0] features;
    logic [TGT_W-1:0]  target;
    logic [MODE_W-1:0] mode;
  } req_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] potential;
    logic signed [WEIGHT_W-1:0] error;
    logic                       class_out;
    logic                       saturated;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic acc_en;
    logic pot_en;
    logic err_en;
    logic mul_en;
    logic dlt_en;
    logic upd_en;
  } ctrl_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] val;
    logic                       hit;
  } sat_res_t;

  function automatic sat_res_t sat32(logic signed [63:0] v);
    sat_res_t r;
    if (v > S32_MAX) begin
      r.val = WEIGHT_W'(S32_MAX);
      r.hit = 1'b1;
    end else if (v < S32_MIN) begin
      r.val = WEIGHT_W'(S32_MIN);
      r.hit = 1'b1;
    end else begin
      r.val = WEIGHT_W'(v);
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

/* design/lmsn_stream_if.sv */
`timescale 1ns / 1ps
// lmsn_stream_if: valid/ready channel carrying one request or result.
// Payload type is a parameter; users pass types from lmsn_pkg.
interface lmsn_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/lmsn_cell.sv */
`timescale 1ns / 1ps
// lmsn_cell: one ring cell holding a weight and the feature bit of its slot.
// Depends on lmsn_pkg.
module lmsn_cell
  import lmsn_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic                       shift_i,
  input  logic                       feat_load_i,
  input  logic                       feat_in_i,
  input  logic signed [WEIGHT_W-1:0] w_in_i,
  output logic signed [WEIGHT_W-1:0] w_o,
  output logic                       feat_o
);

  logic signed [WEIGHT_W-1:0] w_q;
  logic                       feat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= '0;
      feat_q <= 1'b0;
    end else if (load_i) begin
      feat_q <= feat_load_i;
    end else if (shift_i) begin
      w_q    <= w_in_i;
      feat_q <= feat_in_i;
    end
  end

  assign w_o    = w_q;
  assign feat_o = feat_q;

endmodule

/* design/lmsn_head.sv */
`timescale 1ns / 1ps
// lmsn_head: ring head; accumulates the potential, forms error and step,
// and writes back updated weights into the ring. Depends on lmsn_pkg.
module lmsn_head
  import lmsn_pkg::*;
#(
  parameter int unsigned NUM_FEATURES  = 48,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctrl_t                      ctrl_i,
  input  logic                       feat0_i,
  input  logic signed [WEIGHT_W-1:0] w0_i,
  input  logic [TGT_W-1:0]           target_i,
  input  logic [MODE_W-1:0]          mode_i,
  input  logic [LR_W-1:0]            lr_i,
  input  logic [THR_W-1:0]           thr_i,
  output logic signed [WEIGHT_W-1:0] wb_o,
  output rsp_t                       rsp_o
);

  localparam int unsigned ACC_W = WEIGHT_W + $clog2(NUM_FEATURES + 1);
  localparam logic signed [PROD_W:0] RND_HALF = (PROD_W + 1)'(1) <<< (RATE_FRAC - 1);

  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [WEIGHT_W-1:0] pot_q, err_q;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [DELTA_W-1:0]  delta_q;
  logic signed [PROD_W:0]     rnd;
  logic signed [ERR_W-1:0]    tgt_s, diff;
  logic signed [UPD_W-1:0]    upd_sum;
  logic [WEIGHT_W-1:0]        mag;
  logic                       cls_q, cls_d;
  logic                       sat_q, sat_d;
  sat_res_t                   pot_r, err_r, upd_r;

  always_comb begin
    acc_d   = acc_q + ACC_W'(w0_i);
    pot_r   = sat32(64'(acc_q));
    tgt_s   = $signed({{(ERR_W - TGT_W){1'b0}}, target_i}) <<< FRACTION_BITS;
    diff    = tgt_s - ERR_W'(pot_q);
    err_r   = sat32(64'(diff));
    mag     = pot_q[WEIGHT_W-1] ? (~pot_q + WEIGHT_W'(1)) : pot_q;
    cls_d   = (mode_i == MODE_CLASS) && (mag >= {1'b0, thr_i});
    prod_d  = PROD_W'($signed({1'b0, lr_i})) * PROD_W'(err_q);
    rnd     = (PROD_W + 1)'(prod_q) + RND_HALF;
    upd_sum = UPD_W'(w0_i) + UPD_W'(delta_q);
    upd_r   = sat32(64'(upd_sum));
    wb_o    = (ctrl_i.upd_en && feat0_i) ? upd_r.val : w0_i;
    sat_d   = sat_q;
    if (ctrl_i.pot_en) sat_d = sat_q | pot_r.hit;
    if (ctrl_i.err_en) sat_d = sat_q | err_r.hit;
    if (ctrl_i.upd_en) sat_d = sat_q | (feat0_i & upd_r.hit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
      cls_q <= 1'b0;
    end else if (ctrl_i.start) begin
      acc_q <= '0;
      sat_q <= 1'b0;
      cls_q <= 1'b0;
    end else begin
      if (ctrl_i.acc_en && feat0_i) acc_q <= acc_d;
      if (ctrl_i.err_en) cls_q <= cls_d;
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pot_en) pot_q <= pot_r.val;
    if (ctrl_i.err_en) err_q <= err_r.val;
    if (ctrl_i.mul_en) prod_q <= prod_d;
    if (ctrl_i.dlt_en) delta_q <= rnd[PROD_W:RATE_FRAC];
  end

  assign rsp_o = '{potential: pot_q, error: err_q, class_out: cls_q, saturated: sat_q};

endmodule

/* design/lms_neuron_trainer.sv */
`timescale 1ns / 1ps
// lms_neuron_trainer: single linear neuron with LMS weight training.
// Depends on lmsn_pkg, lmsn_stream_if, lmsn_cell and lmsn_head.
//
//   port    dir   type    contents
//   req_i   sink  req_t   features, target, mode
//   res_o   src   rsp_t   potential, error, class_out, saturated
//   cfg_*   in    write   idx 0 learning_rate, idx 1 decision_threshold
//
// Weights sit in a ring of NUM_FEATURES cells rotating one slot a cycle during the sum and update passes.
// Evaluate/classify: one ring pass per request, then potential and error steps.
// Train: sum pass, step calc, update pass.
// Reset clears all weights at once; no clearing pass.
// A finished result waits in the output register; a new request is taken
// while it is held, and the core stalls only when a second one is done.
module lms_neuron_trainer
  import lmsn_pkg::*;
#(
  parameter int unsigned NUM_FEATURES  = 48,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lmsn_stream_if.sink           req_i,
  lmsn_stream_if.source         res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CNT_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_FEATURES - 1);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1) << (FRACTION_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_POT,
    ST_ERR,
    ST_MUL,
    ST_DLT,
    ST_UPD,
    ST_DONE
  } state_e;

  state_e                     state_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [MODE_W-1:0]          mode_q;
  logic [TGT_W-1:0]           target_q;
  logic [LR_W-1:0]            lr_q;
  logic [THR_W-1:0]           thr_q;
  logic                       res_valid_q;
  rsp_t                       res_data_q;
  rsp_t                       head_rsp;
  ctrl_t                      ctrl;
  logic                       req_ready;
  logic                       shift;
  logic                       out_free;
  logic signed [WEIGHT_W-1:0] wb;
  logic signed [WEIGHT_W-1:0] w    [NUM_FEATURES];
  logic                       feat [NUM_FEATURES];

  assign req_ready   = (state_q == ST_IDLE);
  assign req_i.ready = req_ready;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_data_q;
  assign out_free    = !res_valid_q || res_o.ready;

  always_comb begin
    ctrl        = '0;
    ctrl.start  = req_i.valid && req_ready;
    ctrl.acc_en = (state_q == ST_SUM);
    ctrl.pot_en = (state_q == ST_POT);
    ctrl.err_en = (state_q == ST_ERR);
    ctrl.mul_en = (state_q == ST_MUL);
    ctrl.dlt_en = (state_q == ST_DLT);
    ctrl.upd_en = (state_q == ST_UPD);
  end

  assign shift = ctrl.acc_en | ctrl.upd_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= LR_RESET;
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEARNING_RATE: lr_q  <= cfg_wdata_i[LR_W-1:0];
        CFG_THRESHOLD:     thr_q <= cfg_wdata_i[THR_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      mode_q      <= '0;
      target_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && out_free) res_valid_q <= 1'b1;
      else if (res_o.ready) res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (ctrl.start) begin
            mode_q   <= req_i.data.mode;
            target_q <= req_i.data.target;
            cnt_q    <= CNT_LAST;
            state_q  <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (cnt_q == '0) state_q <= ST_POT;
          else cnt_q <= cnt_q - CNT_W'(1);
        end
        ST_POT: state_q <= ST_ERR;
        ST_ERR: state_q <= (mode_q == MODE_TRAIN) ? ST_MUL : ST_DONE;
        ST_MUL: state_q <= ST_DLT;
        ST_DLT: begin
          cnt_q   <= CNT_LAST;
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (cnt_q == '0) state_q <= ST_DONE;
          else cnt_q <= cnt_q - CNT_W'(1);
        end
        ST_DONE: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) res_data_q <= head_rsp;
  end

  for (genvar i = 0; i < NUM_FEATURES; i++) begin : g_cell
    logic                       feat_load;
    logic                       feat_in;
    logic signed [WEIGHT_W-1:0] w_in;

    if (i < FEAT_W) begin : g_bit
      assign feat_load = req_i.data.features[i];
    end else begin : g_pad
      assign feat_load = 1'b0;
    end

    if (i == NUM_FEATURES - 1) begin : g_tail
      assign w_in    = wb;
      assign feat_in = feat[0];
    end else begin : g_link
      assign w_in    = w[i+1];
      assign feat_in = feat[i+1];
    end

    lmsn_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (ctrl.start),
      .shift_i     (shift),
      .feat_load_i (feat_load),
      .feat_in_i   (feat_in),
      .w_in_i      (w_in),
      .w_o         (w[i]),
      .feat_o      (feat[i])
    );
  end

  lmsn_head #(
    .NUM_FEATURES  (NUM_FEATURES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_head (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .feat0_i  (feat[0]),
    .w0_i     (w[0]),
    .target_i (target_q),
    .mode_i   (mode_q),
    .lr_i     (lr_q),
    .thr_i    (thr_q),
    .wb_o     (wb),
    .rsp_o    (head_rsp)
  );

`ifndef SYNTHESIS
  a_ready_no_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready |-> !shift)
    else $error("ring shifting while request accepted");

  a_upd_only_train: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (mode_q == MODE_TRAIN))
    else $error("weight update outside train mode");

  a_sum_to_pot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM && cnt_q == '0) |=> (state_q == ST_POT))
    else $error("sum pass did not end after full rotation");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> res_valid_q && (state_q == ST_IDLE))
    else $error("finished result not loaded");
`endif

endmodule

/* tb/lmsn_neuron_monitor.sv */
`timescale 1ns / 1ps
// lmsn_neuron_monitor: watches the request, result and register ports of
// the LMS neuron, predicts each response and compares. Depends on lmsn_pkg.
module lmsn_neuron_monitor
  import lmsn_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  input  req_t                  req_data_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  rsp_t                  res_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    mismatches_o,
  output int                    outstanding_o,
  output int                    sat_seen_o,
  output int                    class_seen_o
);

  localparam int unsigned FRAC_BITS  = 16;
  localparam int          REPORT_MAX = 10;
  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (RATE_FRAC - 1);

  logic signed [WEIGHT_W-1:0] weight_q [FEAT_W];
  logic [LR_W-1:0]            rate_q;
  logic [THR_W-1:0]           thresh_q;
  rsp_t                       expected_q [$];
  rsp_t                       want;
  int                         mismatches = 0;
  int                         sat_seen = 0;
  int                         class_seen = 0;

  function automatic logic signed [WEIGHT_W-1:0] clamp_s32(input logic signed [63:0] v,
                                                           output logic hit);
    logic signed [WEIGHT_W-1:0] c;
    hit = 1'b1;
    if (v > 64'sd2147483647) c = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) c = 32'sh8000_0000;
    else begin
      c = WEIGHT_W'(v);
      hit = 1'b0;
    end
    return c;
  endfunction

  // potential/error from current weights; train mode steps the weights
  function automatic rsp_t neuron_response(input req_t r);
    logic signed [63:0] acc, tgt, prod, delta, mag, thr;
    logic signed [WEIGHT_W-1:0] pot, err;
    logic hit, sat;
    rsp_t o;
    acc = '0;
    sat = 1'b0;
    for (int i = 0; i < FEAT_W; i++)
      if (r.features[i]) acc = acc + weight_q[i];
    pot = clamp_s32(acc, hit);
    sat |= hit;
    tgt = 64'(r.target) << FRAC_BITS;
    err = clamp_s32(tgt - pot, hit);
    sat |= hit;
    o.class_out = 1'b0;
    if (r.mode == MODE_TRAIN) begin
      prod = $signed({48'd0, rate_q}) * err;
      delta = (prod + ROUND_HALF) >>> RATE_FRAC;
      for (int i = 0; i < FEAT_W; i++) begin
        if (r.features[i]) begin
          weight_q[i] = clamp_s32(weight_q[i] + delta, hit);
          sat |= hit;
        end
      end
    end else if (r.mode == MODE_CLASS) begin
      mag = pot;
      if (mag < 0) mag = -mag;
      thr = {33'd0, thresh_q};
      o.class_out = (mag >= thr);
    end
    o.potential = pot;
    o.error     = err;
    o.saturated = sat;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FEAT_W; i++) weight_q[i] = '0;
      rate_q   = LR_RESET;
      thresh_q = THR_W'(32'd1 << (FRAC_BITS - 1));
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_LEARNING_RATE) rate_q = cfg_wdata_i[LR_W-1:0];
        else if (cfg_idx_i == CFG_THRESHOLD) thresh_q = cfg_wdata_i[THR_W-1:0];
      end
      if (req_valid_i && req_ready_i) expected_q.push_back(neuron_response(req_data_i));
      if (res_valid_i && res_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected response pot=%0d err=%0d cls=%0b sat=%0b", $time,
                     $signed(res_data_i.potential), $signed(res_data_i.error),
                     res_data_i.class_out, res_data_i.saturated);
        end else begin
          want = expected_q.pop_front();
          if (want.saturated) sat_seen++;
          if (want.class_out) class_seen++;
          if (res_data_i.potential !== want.potential || res_data_i.error !== want.error ||
              res_data_i.class_out !== want.class_out ||
              res_data_i.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: response mismatch: exp pot=%0d err=%0d cls=%0b sat=%0b, got pot=%0d err=%0d cls=%0b sat=%0b",
                       $time, $signed(want.potential), $signed(want.error), want.class_out,
                       want.saturated, $signed(res_data_i.potential),
                       $signed(res_data_i.error), res_data_i.class_out,
                       res_data_i.saturated);
          end
        end
      end
    end
    mismatches_o  <= mismatches;
    outstanding_o <= expected_q.size();
    sat_seen_o    <= sat_seen;
    class_seen_o  <= class_seen;
  end

endmodule

/* tb/lms_neuron_trainer_test.sv */
`timescale 1ns / 1ps
// lms_neuron_trainer_test: stimulus and verdict for the LMS neuron trainer.
// Depends on lmsn_pkg, lmsn_stream_if, lms_neuron_trainer, lmsn_neuron_monitor.
module lms_neuron_trainer_test;
  import lmsn_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [FEAT_W-1:0] ALL_ONES   = {FEAT_W{1'b1}};
  localparam logic [THR_W-1:0]  THR_MAX    = {THR_W{1'b1}};
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 120;
  localparam int HOLD_AT     = 350;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int END_SETTLE  = 2 * FEAT_W + 10;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count, outstanding, sat_seen, class_seen;
  int req_count = 0;
  int idle_run = 0;
  int burst_left = 0;
  int settings_used = 0;
  int mode_tally [4] = '{0, 0, 0, 0};
  logic [FEAT_W-1:0] digit_pat [10];

  lmsn_stream_if #(.payload_t(req_t)) req_ch ();
  lmsn_stream_if #(.payload_t(rsp_t)) res_ch ();

  lms_neuron_trainer uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  lmsn_neuron_monitor u_monitor (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_valid_i   (req_ch.valid),
    .req_ready_i   (req_ch.ready),
    .req_data_i    (req_ch.data),
    .res_valid_i   (res_ch.valid),
    .res_ready_i   (res_ch.ready),
    .res_data_i    (res_ch.data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (fail_count),
    .outstanding_o (outstanding),
    .sat_seen_o    (sat_seen),
    .class_seen_o  (class_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (req_ch.valid && req_ch.ready) req_count <= req_count + 1;
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("lms_neuron_trainer_test: done, errors");
      $finish;
    end
  end

  function automatic logic [FEAT_W-1:0] rand_features();
    return FEAT_W'({$urandom(), $urandom()});
  endfunction

  function automatic req_t make_req(input logic [FEAT_W-1:0] f, input int t,
                                    input logic [MODE_W-1:0] m);
    req_t r;
    r.features = f;
    r.target   = TGT_W'(t);
    r.mode     = m;
    return r;
  endfunction

  // mostly the digit patterns, biased to train, plus sparse and raw noise
  function automatic req_t random_request();
    int kind, d, p;
    logic [FEAT_W-1:0] f;
    logic [MODE_W-1:0] m;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      d = $urandom_range(0, 9);
      f = digit_pat[d];
      if ($urandom_range(0, 4) == 0) f ^= FEAT_W'(1) << $urandom_range(0, FEAT_W - 1);
      p = $urandom_range(0, 19);
      if (p < 11) m = MODE_TRAIN;
      else if (p < 14) m = MODE_EVAL;
      else if (p < 19) m = MODE_CLASS;
      else m = MODE_SPARE;
      return make_req(f, d, m);
    end
    if (kind < 8) begin
      f = '0;
      repeat ($urandom_range(1, 4)) f |= FEAT_W'(1) << $urandom_range(0, FEAT_W - 1);
    end else begin
      f = rand_features();
    end
    return make_req(f, $urandom_range(0, 15), MODE_W'($urandom_range(0, 3)));
  endfunction

  task automatic send_request(input req_t r);
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    mode_tally[r.mode]++;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic feed(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_request(r);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [LR_W-1:0] rate, input logic [THR_W-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_LEARNING_RATE;
    cfg_wdata <= CFG_DATA_W'(rate);
    @(posedge clk);
    cfg_idx   <= CFG_THRESHOLD;
    cfg_wdata <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // result side: changing stall styles, plus one long hold-off mid-run
  initial begin
    int style, span;
    bit held;
    style = 0;
    span = 0;
    held = 1'b0;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held && req_count >= HOLD_AT) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        if (span == 0) begin
          style = $urandom_range(0, 3);
          span = $urandom_range(8, 80);
        end
        span--;
        case (style)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= $urandom_range(0, 1);
          2: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= (span % 4 != 0);
        endcase
      end
    end
  end

  initial begin
    rst_n        <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_LEARNING_RATE;
    cfg_wdata    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    send_request(make_req('0, 0, MODE_TRAIN));
    send_request(make_req(ALL_ONES, 9, MODE_TRAIN));
    send_request(make_req(ALL_ONES, 9, MODE_EVAL));
    send_request(make_req(ALL_ONES, 15, MODE_EVAL));
    send_request(make_req(FEAT_W'(1), 0, MODE_TRAIN));
    send_request(make_req(FEAT_W'(1) << (FEAT_W - 1), 9, MODE_TRAIN));
    send_request(make_req(ALL_ONES, 0, MODE_SPARE));
    send_request(make_req(ALL_ONES, 5, MODE_CLASS));
    send_request(make_req('0, 9, MODE_CLASS));
    drain();

    // full step size diverges and drives sums and weights into the rails
    program_regs({LR_W{1'b1}}, THR_MAX);
    repeat (5) send_request(make_req(ALL_ONES, 15, MODE_TRAIN));
    send_request(make_req(ALL_ONES, 0, MODE_CLASS));
    send_request(make_req(FEAT_W'(1) << (FEAT_W - 1), 0, MODE_CLASS));
    drain();

    program_regs('0, '0);
    send_request(make_req(ALL_ONES, 9, MODE_TRAIN));
    send_request(make_req(rand_features(), 3, MODE_CLASS));
    send_request(make_req('0, 0, MODE_CLASS));
    drain();

    foreach (digit_pat[i]) digit_pat[i] = rand_features();
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_regs(LR_RESET, THR_W'(32768));
        1: program_regs(LR_W'(1), THR_MAX);
        2: program_regs(LR_W'(4096), '0);
        3: program_regs(LR_W'($urandom()), THR_W'($urandom()));
        4: program_regs({LR_W{1'b1}}, THR_W'(1) << 18);
        5: program_regs('0, THR_W'(1));
        default: program_regs(LR_W'($urandom_range(1, 2000)), THR_W'($urandom()));
      endcase
      repeat (PHASE_ITEMS) feed(random_request());
      drain();
    end

    repeat (END_SETTLE) @(posedge clk);
    $display("covered %0d requests (train %0d, evaluate %0d, classify %0d, spare mode %0d)",
             req_count, mode_tally[0], mode_tally[1], mode_tally[2], mode_tally[3]);
    $display("%0d register settings, %0d saturated responses, %0d classified as one",
             settings_used, sat_seen, class_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("lms_neuron_trainer_test: done, clean");
    end else begin
      $display("lms_neuron_trainer_test: done, errors");
    end
    $finish;
  end

endmodule

/* lms_neuron_trainer.f */
design/lmsn_pkg.sv
design/lmsn_stream_if.sv
design/lmsn_cell.sv
design/lmsn_head.sv
design/lms_neuron_trainer.sv
tb/lmsn_neuron_monitor.sv
tb/lms_neuron_trainer_test.sv
